// ===== rtl/rpfl_pkg.sv =====
// Shared constants, codes and types of the reference-counted page free list.
package rpfl_pkg;

  localparam int unsigned NumPages  = 32768;
  localparam int unsigned PageBytes = 4096;
  localparam logic [31:0] BaseAddr  = 32'h8000_0000;
  localparam int unsigned FirstFree = 256;

  localparam int unsigned IdxW      = $clog2(NumPages);
  localparam int unsigned PageShift = $clog2(PageBytes);
  localparam int unsigned CntW      = $clog2(NumPages + 1);
  localparam int unsigned RefW      = 8;
  localparam logic [RefW-1:0] RefMax = {RefW{1'b1}};

  localparam int unsigned InitFree  = (FirstFree < NumPages) ? NumPages - FirstFree : 0;

  localparam int unsigned AddrW     = 32;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatW     = 2;
  localparam int unsigned InDataW   = ((OpW + AddrW + 7) / 8) * 8;
  localparam int unsigned OutBits   = StatW + AddrW + 1 + RefW;
  localparam int unsigned OutDataW  = ((OutBits + 7) / 8) * 8;

  localparam logic [OpW-1:0] OpAlloc  = 2'd0;
  localparam logic [OpW-1:0] OpFree   = 2'd1;
  localparam logic [OpW-1:0] OpAddRef = 2'd2;

  localparam logic [StatW-1:0] StOk      = 2'd0;
  localparam logic [StatW-1:0] StOom     = 2'd1;
  localparam logic [StatW-1:0] StBadAddr = 2'd2;
  localparam logic [StatW-1:0] StNotUsed = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ===== rtl/refcounted_page_free_list.sv =====
// Page allocator top level: LIFO free list and per-page reference counts in block RAM.
//
// Each transaction on the slave stream is one command (allocate, free, add reference) and
// gives exactly one result on the master stream. In the accept cycle the link and count
// memories are read at the list head and the addressed page; in the execute state that
// follows, the result is formed, the memories are written back and the head moves. The
// next command is taken only back in the idle state, so the block never takes a new command
// before the last is through; the execute state is held only while the output register
// still holds a result that the sink has not taken. No clearing pass follows reset: the
// pages of the initial list never handed out form a contiguous run below a high-water mark,
// whose links and counts are implied (next lower page, count zero), not read from memory.
module refcounted_page_free_list (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] opcode, [33:2] page_address, [39:34] zero
  input  logic [rpfl_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] status, [33:2] granted_address, [34] returned_to_pool, [42:35] count_after,
  // [47:43] zero
  output logic [rpfl_pkg::OutDataW-1:0] m_axis_tdata
);
  import rpfl_pkg::*;

  logic [IdxW-1:0] link_mem [NumPages];
  logic [RefW-1:0] ref_mem  [NumPages];

  state_e          state_q, state_d;
  logic [OpW-1:0]  op_q;
  logic [IdxW-1:0] idx_q;
  logic            bad_q;
  logic [IdxW-1:0] top_q, top_d;
  logic [IdxW:0]   run_end_q, run_end_d;
  logic [CntW-1:0] free_cnt_q, free_cnt_d;
  logic [IdxW-1:0] link_rd_q;
  logic [RefW-1:0] ref_rd_q;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic             in_accept;
  logic [OpW-1:0]   in_op;
  logic [AddrW-1:0] in_addr;
  logic [AddrW-1:0] addr_off;
  logic [AddrW-1:0] page_num;
  logic             addr_bad;
  logic [IdxW-1:0]  rd_idx;

  logic             exec_go;
  logic             idx_in_run;
  logic             top_in_run;
  logic [RefW-1:0]  cur_cnt;
  logic [IdxW-1:0]  next_top;
  logic             ref_we;
  logic [RefW-1:0]  ref_wd;
  logic             link_we;
  logic [IdxW-1:0]  link_wd;
  logic [StatW-1:0] res_status;
  logic [AddrW-1:0] res_granted;
  logic             res_pushed;
  logic [RefW-1:0]  res_cnt;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tdata[OpW-1:0];
  assign in_addr       = s_axis_tdata[OpW+AddrW-1:OpW];

  // Decode the byte address into a page index and range check it.
  assign addr_off = in_addr - BaseAddr;
  assign page_num = addr_off >> PageShift;
  assign addr_bad = (|in_addr[PageShift-1:0]) || (in_addr < BaseAddr) ||
                    (page_num < AddrW'(FirstFree)) || (page_num >= AddrW'(NumPages));
  assign rd_idx   = (in_op == OpAlloc) ? top_q : page_num[IdxW-1:0];

  assign exec_go    = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);
  assign idx_in_run = ({1'b0, idx_q} < run_end_q);
  assign top_in_run = ({1'b0, top_q} < run_end_q);
  assign cur_cnt    = idx_in_run ? '0 : ref_rd_q;
  assign next_top   = top_in_run ? top_q - IdxW'(1) : link_rd_q;

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    run_end_d   = run_end_q;
    free_cnt_d  = free_cnt_q;
    ref_we      = 1'b0;
    ref_wd      = '0;
    link_we     = 1'b0;
    link_wd     = '0;
    res_status  = StOk;
    res_granted = '0;
    res_pushed  = 1'b0;
    res_cnt     = '0;

    case (op_q)
      OpAlloc: begin
        if (free_cnt_q == '0) begin
          res_status = StOom;
        end else begin
          res_granted = BaseAddr + (AddrW'(idx_q) << PageShift);
          res_cnt     = RefW'(1);
          ref_we      = 1'b1;
          ref_wd      = RefW'(1);
          top_d       = next_top;
          free_cnt_d  = free_cnt_q - CntW'(1);
          // Popping the top of the untouched run lowers the high-water mark.
          if (top_in_run) begin
            run_end_d = {1'b0, top_q};
          end
        end
      end
      OpFree: begin
        if (bad_q) begin
          res_status = StBadAddr;
        end else if (cur_cnt == '0) begin
          res_status = StNotUsed;
        end else if (cur_cnt > RefW'(1)) begin
          ref_we  = 1'b1;
          ref_wd  = cur_cnt - RefW'(1);
          res_cnt = cur_cnt - RefW'(1);
        end else begin
          ref_we     = 1'b1;
          ref_wd     = '0;
          link_we    = 1'b1;
          link_wd    = (free_cnt_q != '0) ? top_q : '0;
          top_d      = idx_q;
          free_cnt_d = free_cnt_q + CntW'(1);
          res_pushed = 1'b1;
        end
      end
      OpAddRef: begin
        if (bad_q) begin
          res_status = StBadAddr;
        end else if (cur_cnt == '0) begin
          res_status = StNotUsed;
        end else begin
          ref_we  = 1'b1;
          ref_wd  = (cur_cnt == RefMax) ? RefMax : cur_cnt + RefW'(1);
          res_cnt = ref_wd;
        end
      end
      default: begin
      end
    endcase

    // Commit nothing unless the result can be stored.
    if (!exec_go) begin
      top_d      = top_q;
      run_end_d  = run_end_q;
      free_cnt_d = free_cnt_q;
      ref_we     = 1'b0;
      link_we    = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      top_q      <= IdxW'(NumPages - 1);
      run_end_q  <= (IdxW + 1)'(NumPages);
      free_cnt_q <= CntW'(InitFree);
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      run_end_q  <= run_end_d;
      free_cnt_q <= free_cnt_d;
      if (exec_go) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Command and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= in_op;
      idx_q <= rd_idx;
      bad_q <= addr_bad;
    end
    if (exec_go) begin
      m_data_q <= {(OutDataW - OutBits)'(0), res_cnt, res_pushed, res_granted, res_status};
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[idx_q] <= link_wd;
    end
    if (in_accept) begin
      link_rd_q <= link_mem[top_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[idx_q] <= ref_wd;
    end
    if (in_accept) begin
      ref_rd_q <= ref_mem[rd_idx];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/rpfl_checker.sv =====
// Port-level checker for the page free list, bound to the top level.
module rpfl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rpfl_pkg::OutDataW-1:0] m_axis_tdata
);
  import rpfl_pkg::*;

  logic [StatW-1:0] out_status;
  logic [AddrW-1:0] out_granted;
  logic             out_pushed;
  logic [RefW-1:0]  out_cnt;

  assign out_status  = m_axis_tdata[StatW-1:0];
  assign out_granted = m_axis_tdata[StatW+AddrW-1:StatW];
  assign out_pushed  = m_axis_tdata[StatW+AddrW];
  assign out_cnt     = m_axis_tdata[StatW+AddrW+RefW:StatW+AddrW+1];

  // One command in flight: no new transaction right after an accepted one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a command is in flight");

  // A fresh result follows an accepted command.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching command");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Failures report no page and no count.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (out_status != StOk) |->
      (out_granted == '0) && (out_cnt == '0) && !out_pushed)
    else $error("failed command reports a page or count");

  // A page returned to the pool has count zero and no grant.
  a_push_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_pushed |-> (out_cnt == '0) && (out_granted == '0))
    else $error("returned page reports nonzero count or grant");

endmodule

bind refcounted_page_free_list rpfl_checker u_rpfl_checker (.*);

// ===== bench/refcounted_page_free_list_tb.sv =====
// Self-checking testbench for the reference-counted page free list allocator.
`timescale 1ns / 100ps

module refcounted_page_free_list_tb;
  import rpfl_pkg::*;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned CycleLimit = 500_000;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [AddrW-1:0] granted;
    logic             returned;
    logic [RefW-1:0]  count;
  } page_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  // Shadow copy of the allocator state
  logic [IdxW-1:0] next_link [NumPages];
  logic [RefW-1:0] ref_count [NumPages];
  logic [IdxW-1:0] top_page;
  int unsigned     pages_free;
  int unsigned     live_pages[$];

  page_result_t awaited_results[$];
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;

  refcounted_page_free_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b0;
    #1 clk_i = 1'b1;
  end

  function automatic logic [AddrW-1:0] page_addr(int unsigned idx);
    return BaseAddr + AddrW'(idx) * AddrW'(PageBytes);
  endfunction

  // Push every page from the first free one upward, highest ends on top
  function automatic void reset_page_model();
    for (int unsigned p = 0; p < NumPages; p++) begin
      next_link[p] = '0;
      ref_count[p] = '0;
    end
    top_page   = '0;
    pages_free = 0;
    for (int unsigned p = FirstFree; p < NumPages; p++) begin
      if (pages_free != 0) next_link[p] = top_page;
      top_page = IdxW'(p);
      pages_free++;
    end
  endfunction

  function automatic page_result_t predict_page_op(logic [OpW-1:0] op, logic [AddrW-1:0] addr);
    page_result_t      r;
    logic [AddrW-1:0]  delta;
    int unsigned       offs;
    logic              addr_ok;
    logic [IdxW-1:0]   pg;
    r       = '0;
    addr_ok = 1'b0;
    pg      = '0;
    if ((addr % PageBytes) == 0 && addr >= BaseAddr) begin
      delta = addr - BaseAddr;
      offs  = delta / PageBytes;
      if (offs >= FirstFree && offs < NumPages) begin
        addr_ok = 1'b1;
        pg      = IdxW'(offs);
      end
    end
    case (op)
      OpAlloc: begin
        if (pages_free == 0) begin
          r.status = StOom;
        end else begin
          pg            = top_page;
          top_page      = next_link[pg];
          pages_free--;
          ref_count[pg] = RefW'(1);
          r.granted     = page_addr(32'(pg));
          r.count       = RefW'(1);
          live_pages.push_back(32'(pg));
        end
      end
      OpFree, OpAddRef: begin
        if (!addr_ok) begin
          r.status = StBadAddr;
        end else if (ref_count[pg] == 0) begin
          r.status = StNotUsed;
        end else if (op == OpFree) begin
          if (ref_count[pg] > 1) begin
            ref_count[pg]--;
            r.count = ref_count[pg];
          end else begin
            ref_count[pg] = '0;
            next_link[pg] = (pages_free != 0) ? top_page : '0;
            top_page      = pg;
            pages_free++;
            r.returned    = 1'b1;
          end
        end else begin
          if (ref_count[pg] != RefMax) ref_count[pg]++;
          r.count = ref_count[pg];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Caller sits on a rising edge; returns on the edge that takes the transaction
  task automatic send_command(logic [OpW-1:0] op, logic [AddrW-1:0] addr);
    awaited_results.push_back(predict_page_op(op, addr));
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW - OpW - AddrW){1'b0}}, addr, op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic report_field(string name, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    page_result_t want;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, m_axis_tdata);
      end else begin
        want = awaited_results.pop_front();
        report_field("status", want.status, m_axis_tdata[1:0]);
        report_field("granted_address", want.granted, m_axis_tdata[33:2]);
        report_field("returned_to_pool", want.returned, m_axis_tdata[34]);
        report_field("count_after", want.count, m_axis_tdata[42:35]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("refcounted_page_free_list verification failed");
      $finish;
    end
  end

  task automatic test_directed_corners();
    send_command(OpAlloc, '0);                          // top page comes out first
    send_command(OpAlloc, 32'hFFFF_FFFF);               // address ignored on allocate
    send_command(OpAddRef, page_addr(NumPages - 1));
    send_command(OpFree, page_addr(NumPages - 1));      // count drops to one
    send_command(OpFree, page_addr(NumPages - 1));      // page goes back on the list
    send_command(OpFree, page_addr(NumPages - 1));      // no longer in use
    send_command(OpAddRef, page_addr(NumPages - 1));
    send_command(OpFree, page_addr(NumPages - 2) | 32'h1);
    send_command(OpAddRef, page_addr(NumPages - 2) | 32'h800);
    send_command(OpFree, 32'h0000_0000);
    send_command(OpAddRef, BaseAddr - PageBytes);
    send_command(OpFree, page_addr(FirstFree - 1));
    send_command(OpFree, page_addr(FirstFree));         // never handed out
    send_command(OpFree, page_addr(NumPages));
    send_command(OpAddRef, 32'hFFFF_F000);
    send_command(OpUnused, 32'hFFFF_FFFF);
    send_command(OpUnused, page_addr(NumPages - 2));
    send_command(OpAlloc, '0);                          // freed page is reused first
    send_command(OpFree, page_addr(NumPages - 2));
    send_command(OpFree, page_addr(NumPages - 1));
  endtask

  task automatic test_count_saturation();
    int unsigned pg;
    send_command(OpAlloc, '0);
    pg = live_pages[$];
    repeat (256) send_command(OpAddRef, page_addr(pg));
    send_command(OpFree, page_addr(pg));
    send_command(OpAddRef, page_addr(pg));
  endtask

  task automatic run_random_mix(int unsigned n_items);
    int unsigned      pick;
    int unsigned      slot;
    int unsigned      pg;
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] addr;
    for (int unsigned k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      op   = $urandom_range(1) ? OpFree : OpAddRef;
      if (pick < 35 || live_pages.size() == 0) begin
        send_command(OpAlloc, $urandom());
      end else if (pick < 70) begin
        slot = $urandom_range(live_pages.size() - 1);
        pg   = live_pages[slot];
        // drop stale entries after using them once as a not-in-use probe
        if (ref_count[pg] == 0) live_pages.delete(slot);
        send_command((pick < 58) ? OpFree : OpAddRef, page_addr(pg));
      end else if (pick < 77) begin
        send_command(op, page_addr($urandom_range(NumPages - 1, FirstFree)));
      end else if (pick < 93) begin
        case ($urandom_range(4))
          0: addr = $urandom();
          1: addr = page_addr($urandom_range(NumPages - 1, FirstFree))
                    | AddrW'($urandom_range(PageBytes - 1, 1));
          2: addr = $urandom_range(BaseAddr - 1, 0);
          3: addr = page_addr($urandom_range(FirstFree - 1, 0));
          default: addr = page_addr($urandom_range((32'hFFFF_FFFF - BaseAddr) / PageBytes,
                                                   NumPages));
        endcase
        send_command(op, addr);
      end else begin
        send_command(OpW'($urandom_range(3)), $urandom());
      end
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    mismatch_count = 0;
    send_idle_pct  = 33;
    recv_idle_pct  = 81;
    reset_page_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_count_saturation();
    run_random_mix(90);

    send_idle_pct = 81;
    recv_idle_pct = 33;
    run_random_mix(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_mix(90);
    s_axis_tvalid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("refcounted_page_free_list verification clean");
    end else begin
      $display("refcounted_page_free_list verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rpfl_pkg.sv
rtl/refcounted_page_free_list.sv
rtl/rpfl_checker.sv
bench/refcounted_page_free_list_tb.sv
